>>> rtl/core/ets_pkg.sv
// Shared types and codes for the event-triggered stopwatch.
package ets_pkg;

  // Action codes carried by a request
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_PRESS = 2'd1;
  localparam logic [1:0] ACT_RESET = 2'd2;

  // Configuration register indexes
  localparam logic CFG_TRIGGER_MODE = 1'b0;
  localparam logic CFG_STOP_TARGET  = 1'b1;

  localparam int TARGET_W = 7;
  localparam int COUNT_W  = 8;

  typedef enum logic [1:0] {
    PH_INACTIVE = 2'd0,
    PH_WAITING  = 2'd1,
    PH_RUNNING  = 2'd2,
    PH_STOPPED  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [63:0] cycle_counter;
    logic [31:0]        vblank_counter;
    logic [15:0]        frame_counter;
    logic               event_flag;
  } ets_in_t;

  typedef struct packed {
    logic [1:0]         phase;
    logic signed [63:0] elapsed_cycles;
    logic signed [31:0] lag_frames;
  } ets_out_t;

endpackage

>>> rtl/core/event_triggered_stopwatch_unit.sv
// Event-triggered stopwatch: input stage, phase control and result register.
// A request is held in the input register, then its result moves into the result register (out_valid).
// Throughput: one request per cycle while the result is not stalled; the single state update sits between the input
// register and the result register, so consecutive requests see each other's state.
// A stalled result holds the pipe: in_ready drops only while both stages are full.
// Reset (rst_n low, synchronous) empties both stages, sets phase inactive, config to
// automatic mode with a stop target of one, and clears all captures and the held elapsed and lag values.
module event_triggered_stopwatch_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ets_pkg::ets_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ets_pkg::ets_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [6:0]        cfg_wdata
);

  // Configuration
  logic                         trigger_mode_r;
  logic [ets_pkg::TARGET_W-1:0] stop_target_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_mode_r <= 1'b0;
      stop_target_r  <= ets_pkg::TARGET_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        ets_pkg::CFG_TRIGGER_MODE: trigger_mode_r <= cfg_wdata[0];
        ets_pkg::CFG_STOP_TARGET:  stop_target_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input stage
  logic             s1_valid_r;
  ets_pkg::ets_in_t s1_data_r;
  logic             s1_adv;   // stage 1 request moves into the result register

  assign s1_adv   = s1_valid_r && (!out_valid || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  // Stopwatch state
  ets_pkg::phase_t             phase_r, phase_nxt;
  logic                        prev_flag_r, prev_flag_nxt;
  logic [ets_pkg::COUNT_W-1:0] event_count_r, event_count_nxt;
  logic signed [63:0]          start_cycle_r, stop_cycle_r;
  logic [31:0]                 start_vblank_r, stop_vblank_r;
  logic [15:0]                 start_frame_r, stop_frame_r;
  logic signed [63:0]          elapsed_r, elapsed_nxt;
  logic signed [31:0]          lag_r, lag_nxt;
  logic                        cap_start, cap_stop;

  // Shared difference datapath: end point is live counters while running,
  // captured stop values once stopped.
  logic                        use_live;
  logic signed [63:0]          end_cycle;
  logic [31:0]                 end_vblank;
  logic [15:0]                 end_frame;
  logic [31:0]                 vb_diff, fr_diff, lag_val;
  logic                        rise, fall;
  logic [ets_pkg::COUNT_W-1:0] count_inc;

  assign use_live   = (phase_r == ets_pkg::PH_RUNNING);
  assign end_cycle  = use_live ? s1_data_r.cycle_counter  : stop_cycle_r;
  assign end_vblank = use_live ? s1_data_r.vblank_counter : stop_vblank_r;
  assign end_frame  = use_live ? s1_data_r.frame_counter  : stop_frame_r;
  assign vb_diff    = end_vblank - start_vblank_r;
  // frame difference kept unwrapped at 16 bits, then taken modulo 2^32
  assign fr_diff    = {16'd0, end_frame} - {16'd0, start_frame_r};
  assign lag_val    = {1'b0, vb_diff[31:1]} - fr_diff;

  assign rise = !prev_flag_r && s1_data_r.event_flag;
  assign fall = prev_flag_r && !s1_data_r.event_flag;
  assign count_inc = (!trigger_mode_r && rise) ? event_count_r + 1'b1 : event_count_r;

  always_comb begin
    phase_nxt       = phase_r;
    prev_flag_nxt   = prev_flag_r;
    event_count_nxt = event_count_r;
    elapsed_nxt     = elapsed_r;
    lag_nxt         = lag_r;
    cap_start       = 1'b0;
    cap_stop        = 1'b0;
    case (s1_data_r.action)
      ets_pkg::ACT_TICK: begin
        prev_flag_nxt = s1_data_r.event_flag;
        case (phase_r)
          ets_pkg::PH_WAITING: begin
            if (trigger_mode_r || fall) begin
              phase_nxt = ets_pkg::PH_RUNNING;
              cap_start = 1'b1;
            end
          end
          ets_pkg::PH_RUNNING: begin
            event_count_nxt = count_inc;
            if (count_inc == {1'b0, stop_target_r}) begin
              phase_nxt = ets_pkg::PH_STOPPED;
              cap_stop  = 1'b1;
            end
            elapsed_nxt = end_cycle - start_cycle_r;
            lag_nxt     = lag_val;
          end
          ets_pkg::PH_STOPPED: begin
            elapsed_nxt = end_cycle - start_cycle_r;
            lag_nxt     = lag_val;
          end
          default: ;
        endcase
      end
      ets_pkg::ACT_PRESS: begin
        case (phase_r)
          ets_pkg::PH_INACTIVE: phase_nxt = ets_pkg::PH_WAITING;
          ets_pkg::PH_RUNNING: begin
            if (trigger_mode_r) begin
              event_count_nxt = {1'b0, stop_target_r};
            end
          end
          ets_pkg::PH_STOPPED: begin
            phase_nxt       = ets_pkg::PH_WAITING;
            event_count_nxt = '0;
          end
          default: ;
        endcase
      end
      ets_pkg::ACT_RESET: begin
        phase_nxt       = ets_pkg::PH_INACTIVE;
        event_count_nxt = '0;
      end
      default: ;  // unused code: state unchanged, result still reported
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= ets_pkg::PH_INACTIVE;
      prev_flag_r    <= 1'b0;
      event_count_r  <= '0;
      start_cycle_r  <= '0;
      stop_cycle_r   <= '0;
      start_vblank_r <= '0;
      stop_vblank_r  <= '0;
      start_frame_r  <= '0;
      stop_frame_r   <= '0;
      elapsed_r      <= '0;
      lag_r          <= '0;
    end else if (s1_adv) begin
      phase_r       <= phase_nxt;
      prev_flag_r   <= prev_flag_nxt;
      event_count_r <= event_count_nxt;
      elapsed_r     <= elapsed_nxt;
      lag_r         <= lag_nxt;
      if (cap_start) begin
        start_cycle_r  <= s1_data_r.cycle_counter;
        start_vblank_r <= s1_data_r.vblank_counter;
        start_frame_r  <= s1_data_r.frame_counter;
      end
      if (cap_stop) begin
        stop_cycle_r  <= s1_data_r.cycle_counter;
        stop_vblank_r <= s1_data_r.vblank_counter;
        stop_frame_r  <= s1_data_r.frame_counter;
      end
    end
  end

  // Result register
  logic              out_valid_r;
  ets_pkg::ets_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r.phase          <= phase_nxt;
      out_data_r.elapsed_cycles <= elapsed_nxt;
      out_data_r.lag_frames     <= lag_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with a free stage");

  a_adv_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced request produced no result");

  a_stop_from_running: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == ets_pkg::PH_STOPPED && $past(phase_r) != ets_pkg::PH_STOPPED)
      |-> $past(phase_r) == ets_pkg::PH_RUNNING)
    else $error("stopped phase entered from other than running");

  a_run_from_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == ets_pkg::PH_RUNNING && $past(phase_r) != ets_pkg::PH_RUNNING)
      |-> $past(phase_r) == ets_pkg::PH_WAITING)
    else $error("running phase entered from other than waiting");

  a_reset_action: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_data_r.action == ets_pkg::ACT_RESET)
      |=> (phase_r == ets_pkg::PH_INACTIVE && event_count_r == '0))
    else $error("reset request did not clear phase and event count");

endmodule

>>> dv/ets_tracker_pkg.sv
// Scoreboard class for the stopwatch bench: tracks stopwatch state and checks results.
`timescale 1ns / 1ps
package ets_tracker_pkg;
  import ets_pkg::*;

  class stopwatch_tracker;
    bit          manual;
    bit [6:0]    target;
    phase_t      cur_phase;
    bit          prev_flag;
    bit [7:0]    evt_count;
    bit [63:0]   start_cyc;
    bit [63:0]   stop_cyc;
    bit [63:0]   elapsed;
    bit [31:0]   start_vb;
    bit [31:0]   stop_vb;
    bit [31:0]   lag;
    bit [15:0]   start_fr;
    bit [15:0]   stop_fr;
    ets_out_t    expected_readings[$];
    int unsigned n_noted;
    int unsigned n_checked;
    int unsigned errors;

    function new();
      target    = 7'd1;
      cur_phase = PH_INACTIVE;
    endfunction

    function void write_reg(logic idx, bit [6:0] val);
      if (idx == CFG_TRIGGER_MODE) manual = val[0];
      else target = val;
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction

    // half the vblank delta minus the unwrapped 16-bit frame delta, mod 2^32
    function bit [31:0] lag_between(bit [31:0] vb_end, bit [31:0] vb_start,
                                    bit [15:0] fr_end, bit [15:0] fr_start);
      bit [31:0] vb_delta;
      bit [31:0] fr_delta;
      vb_delta = vb_end - vb_start;
      fr_delta = {16'd0, fr_end} - {16'd0, fr_start};
      return (vb_delta >> 1) - fr_delta;
    endfunction

    // Apply one accepted request and queue the reading it must produce.
    function void note_request(ets_in_t req);
      ets_out_t want;
      case (req.action)
        ACT_TICK: begin
          case (cur_phase)
            PH_WAITING: begin
              if (manual || (prev_flag && !req.event_flag)) begin
                cur_phase = PH_RUNNING;
                start_cyc = req.cycle_counter;
                start_vb  = req.vblank_counter;
                start_fr  = req.frame_counter;
              end
            end
            PH_RUNNING: begin
              if (!manual && !prev_flag && req.event_flag) evt_count = evt_count + 8'd1;
              if (evt_count == {1'b0, target}) begin
                cur_phase = PH_STOPPED;
                stop_cyc  = req.cycle_counter;
                stop_vb   = req.vblank_counter;
                stop_fr   = req.frame_counter;
              end
              elapsed = req.cycle_counter - start_cyc;
              lag     = lag_between(req.vblank_counter, start_vb, req.frame_counter, start_fr);
            end
            PH_STOPPED: begin
              elapsed = stop_cyc - start_cyc;
              lag     = lag_between(stop_vb, start_vb, stop_fr, start_fr);
            end
            default: ;
          endcase
          prev_flag = req.event_flag;
        end
        ACT_PRESS: begin
          if (cur_phase == PH_INACTIVE) begin
            cur_phase = PH_WAITING;
          end else if (cur_phase == PH_RUNNING && manual) begin
            evt_count = {1'b0, target};
          end else if (cur_phase == PH_STOPPED) begin
            cur_phase = PH_WAITING;
            evt_count = 8'd0;
          end
        end
        ACT_RESET: begin
          cur_phase = PH_INACTIVE;
          evt_count = 8'd0;
        end
        default: ;
      endcase
      want.phase          = cur_phase;
      want.elapsed_cycles = elapsed;
      want.lag_frames     = lag;
      expected_readings.push_back(want);
      n_noted++;
    endfunction

    function void check_result(ets_out_t got);
      ets_out_t want;
      n_checked++;
      if (expected_readings.size() == 0) begin
        $error("result with no request outstanding: phase %0d", got.phase);
        errors++;
        return;
      end
      want = expected_readings.pop_front();
      if (got.phase !== want.phase) begin
        $error("phase: expected %0d, got %0d", want.phase, got.phase);
        errors++;
      end
      if (got.elapsed_cycles !== want.elapsed_cycles) begin
        $error("elapsed_cycles: expected %0d, got %0d",
               want.elapsed_cycles, got.elapsed_cycles);
        errors++;
      end
      if (got.lag_frames !== want.lag_frames) begin
        $error("lag_frames: expected %0d, got %0d", want.lag_frames, got.lag_frames);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> dv/tb.sv
// Top-level bench for the event-triggered stopwatch: stimulus, handshakes and checking.
`timescale 1ns / 1ps
module tb;
  import ets_pkg::*;
  import ets_tracker_pkg::*;

  // action code the block must ignore (still answers with a reading)
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // cycles with no handshake on either side before the run is declared hung;
  // worst legal gap is the long receiver hold (HOLD_CYCLES) plus a drain and cfg writes
  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 60;
  localparam logic [63:0] CYC_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] CYC_MIN = 64'h8000_0000_0000_0000;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  ets_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  ets_out_t out_data;
  logic     cfg_we    = 1'b0;
  logic     cfg_addr  = 1'b0;
  logic [6:0] cfg_wdata = 7'd0;

  stopwatch_tracker tracker;

  // free-running counters fed to the block; they mostly advance like real
  // hardware counters and now and then jump to random values
  bit [63:0] cyc_now;
  bit [31:0] vb_now;
  bit [15:0] fr_now;
  bit        flag_now;
  bit        mode_now;
  bit        in_phase;   // sender is streaming requests of a phase
  bit        calm;       // last part of the run: no idling on either side
  bit        hold_done;
  int        quiet_cycles;

  event_triggered_stopwatch_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic ets_in_t req_of(logic [1:0] act, logic [63:0] cyc, logic [31:0] vb,
                                     logic [15:0] fr, logic flag);
    ets_in_t r;
    r.action         = act;
    r.cycle_counter  = cyc;
    r.vblank_counter = vb;
    r.frame_counter  = fr;
    r.event_flag     = flag;
    return r;
  endfunction

  // Offer one request, optionally after an idle burst; returns once accepted.
  task automatic send_raw(input ets_in_t req);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 12) gap = $urandom_range(1, 19);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(req);
  endtask

  // Request with the counters stepped forward (now and then jumped to random values); flag only matters on ticks.
  task automatic send_item(input logic [1:0] act);
    if ($urandom_range(0, 19) == 0) begin
      cyc_now = {$urandom, $urandom};
      vb_now  = $urandom;
      fr_now  = 16'($urandom);
    end else begin
      cyc_now += 64'($urandom_range(1, 5000));
      vb_now  += 32'($urandom_range(0, 4));
      fr_now  += 16'($urandom_range(0, 3));
    end
    send_raw(req_of(act, cyc_now, vb_now, fr_now,
                    (act == ACT_TICK) ? flag_now : 1'($urandom_range(0, 1))));
  endtask

  // Drop valid and wait for every outstanding reading (every request answers,
  // so an empty queue means the block is idle).
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [6:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    tracker.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One well-formed measurement: arm, then a run of ticks. In manual mode a
  // press somewhere in the run requests the stop. Noise mixes in stray
  // presses, resets and the unused code to break sequences.
  task automatic run_session(input int ticks, input int noise_pct, input bit alternate);
    int         press_at;
    int         k;
    int         pick;
    logic [1:0] act;
    press_at = (ticks > 2) ? $urandom_range(1, ticks - 1) : 1;
    if (noise_pct == 0 || $urandom_range(0, 3) == 0) send_item(ACT_RESET);
    send_item(ACT_PRESS);
    for (k = 0; k < ticks; k++) begin
      act = ACT_TICK;
      if (mode_now && k == press_at) begin
        act = ACT_PRESS;
      end else if ($urandom_range(0, 99) < noise_pct) begin
        pick = $urandom_range(0, 3);
        case (pick)
          0, 1:    act = ACT_PRESS;
          2:       act = ACT_RESET;
          default: act = ACT_UNUSED;
        endcase
      end
      // alternating flag gives a rising edge every second tick
      if (alternate || $urandom_range(0, 9) < 4) flag_now = ~flag_now;
      send_item(act);
    end
  endtask

  // Reprogram while idle, then stream sessions until the budget is used.
  task automatic run_phase(input bit manual, input logic [6:0] target, input int budget,
                           input int noise_pct, input bit alternate,
                           input int min_ticks, input int max_ticks);
    int goal;
    settle();
    write_cfg(CFG_TRIGGER_MODE, {6'd0, manual});
    write_cfg(CFG_STOP_TARGET, target);
    mode_now = manual;
    goal     = tracker.n_noted + budget;
    in_phase = 1'b1;
    while (tracker.n_noted < goal)
      run_session($urandom_range(min_ticks, max_ticks), noise_pct, alternate);
    in_phase = 1'b0;
  endtask

  // Result side: every accepted reading is checked against the oldest request.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_result(out_data);
  end

  // Hang detection: count cycles in which nothing moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: random back-pressure bursts, plus one long hold while the
  // sender keeps offering, so both stages fill and in_ready must drop.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && in_phase && tracker.n_noted >= 150) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < 10) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    tracker = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed: automatic mode, stop target one (reset config) ---
    // tick while inactive does nothing but remember the flag
    send_raw(req_of(ACT_TICK, CYC_MAX, 32'hFFFF_FFFF, 16'hFFFF, 1'b1));
    send_raw(req_of(ACT_UNUSED, CYC_MIN, 32'd0, 16'd0, 1'b0));
    send_raw(req_of(ACT_PRESS, 64'd0, 32'd0, 16'd0, 1'b0));           // arm
    send_raw(req_of(ACT_TICK, CYC_MIN, 32'd0, 16'd0, 1'b1));           // no falling edge
    // falling edge starts; capture the counters at their top values
    send_raw(req_of(ACT_TICK, CYC_MAX, 32'hFFFF_FFFF, 16'hFFFF, 1'b0));
    // rising edge reaches the target: stop with every counter wrapped,
    // frame delta must not wrap at 16 bits
    send_raw(req_of(ACT_TICK, CYC_MIN, 32'd0, 16'd0, 1'b1));
    send_raw(req_of(ACT_TICK, 64'd5, 32'd7, 16'd9, 1'b0));             // stopped: held captures
    send_raw(req_of(ACT_PRESS, 64'd0, 32'd0, 16'd0, 1'b0));           // stopped -> waiting
    send_raw(req_of(ACT_PRESS, 64'd0, 32'd0, 16'd0, 1'b1));           // waiting: ignored
    send_raw(req_of(ACT_TICK, 64'd0, 32'd0, 16'd0, 1'b0));
    send_raw(req_of(ACT_TICK, 64'd0, 32'd0, 16'd0, 1'b1));
    send_raw(req_of(ACT_TICK, 64'd0, 32'd0, 16'd0, 1'b0));             // start at zero
    send_raw(req_of(ACT_PRESS, 64'd0, 32'd0, 16'd0, 1'b0));           // auto running: ignored
    send_raw(req_of(ACT_TICK, '1, 32'hFFFF_FFFF, 16'hFFFF, 1'b0));    // live, large lag
    send_raw(req_of(ACT_RESET, 64'd0, 32'd0, 16'd0, 1'b1));           // captures kept
    send_raw(req_of(ACT_TICK, 64'd0, 32'd0, 16'd0, 1'b0));

    // --- directed: manual mode, press while running forces the stop ---
    settle();
    write_cfg(CFG_TRIGGER_MODE, 7'd1);
    write_cfg(CFG_STOP_TARGET, 7'd2);
    mode_now = 1'b1;
    send_item(ACT_PRESS);
    send_item(ACT_TICK);      // manual: this tick starts the run
    send_item(ACT_TICK);
    send_item(ACT_PRESS);     // count jumps to the target
    send_item(ACT_TICK);      // stops here
    send_item(ACT_TICK);

    // --- random phases ---
    run_phase(1'b0, 7'd1,   25, 10, 1'b0, 4, 20);
    run_phase(1'b1, 7'd0,   25, 10, 1'b0, 3, 12);
    run_phase(1'b0, 7'd0,   20, 10, 1'b0, 3, 12);
    run_phase(1'b0, 7'd3,   35,  8, 1'b0, 4, 30);
    run_phase(1'b1, 7'd5,   25, 10, 1'b0, 3, 15);
    // deep run: a stop target of 99 reached with a clean alternating flag, one session
    run_phase(1'b0, 7'd99, 200,  0, 1'b1, 205, 212);
    run_phase(1'b0, 7'd127, 15, 15, 1'b0, 4, 15);
    run_phase(1'b1, 7'd127, 15, 10, 1'b0, 3, 12);
    calm = 1'b1;
    run_phase(1'b0, 7'($urandom_range(1, 6)), 25, 5, 1'b0, 4, 25);

    settle();
    repeat (4) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
